### hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the calendar date shift unit
// Field widths, status codes, sequencer states and the month length table.
// ----------------------------------------------------------------------------
package cds_pkg;

	// field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int OFFSET_W = 16;
	localparam int STATUS_W = 2;

	// running year may step past the legal range during the month walk, so it is one bit wider
	localparam int YEAR_RUN_W = YEAR_W + 1;
	// day accumulator: day + offset, plus the year residue during reduction
	localparam int ACC_W      = OFFSET_W + 1;
	// year modulo 400
	localparam int R400_W     = 9;

	localparam logic [YEAR_W-1:0]    YEAR_MIN = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]    YEAR_MAX = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0]   MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0]   MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0]   MONTH_DEC = MONTH_W'(12);
	localparam logic [R400_W-1:0]    CYCLE_400 = R400_W'(400);
	localparam logic [R400_W-1:0]    R400_LAST = R400_W'(399);
	localparam logic [R400_W-1:0]    CENT_1    = R400_W'(100);
	localparam logic [R400_W-1:0]    CENT_2    = R400_W'(200);
	localparam logic [R400_W-1:0]    CENT_3    = R400_W'(300);
	localparam logic [DAY_W-1:0]     FEB_LEAP_LEN = DAY_W'(29);

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_DATE  = 2'd1,
		STAT_OUT_RANGE = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MOD   = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_WALK  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// month lengths of a common year, January first
	localparam logic [DAY_W-1:0] BASE_LEN [12] = '{
		DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
		DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
	};

endpackage

### hdl/cds_in_if.sv
// ----------------------------------------------------------------------------
// cds_in_if: input channel of the calendar date shift unit
// Start date and signed day offset with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cds_in_if;
	logic                            valid;
	logic                            ready;
	logic [cds_pkg::YEAR_W-1:0]      in_year;
	logic [cds_pkg::MONTH_W-1:0]     in_month;
	logic [cds_pkg::DAY_W-1:0]       in_day;
	logic signed [cds_pkg::OFFSET_W-1:0] day_offset;

	modport source (
		output valid, in_year, in_month, in_day, day_offset,
		input  ready
	);
	modport sink (
		input  valid, in_year, in_month, in_day, day_offset,
		output ready
	);
endinterface

### hdl/cds_out_if.sv
// ----------------------------------------------------------------------------
// cds_out_if: result channel of the calendar date shift unit
// Shifted date and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cds_out_if;
	logic                            valid;
	logic                            ready;
	logic [cds_pkg::YEAR_W-1:0]      out_year;
	logic [cds_pkg::MONTH_W-1:0]     out_month;
	logic [cds_pkg::DAY_W-1:0]       out_day;
	logic [cds_pkg::STATUS_W-1:0]    status;

	modport source (
		output valid, out_year, out_month, out_day, status,
		input  ready
	);
	modport sink (
		input  valid, out_year, out_month, out_day, status,
		output ready
	);
endinterface

### hdl/cds_month_len.sv
// ----------------------------------------------------------------------------
// cds_month_len: month length lookup
// Length of a month given the year modulo 400; zero for a month outside 1..12.
// ----------------------------------------------------------------------------
module cds_month_len (
	input  logic [cds_pkg::MONTH_W-1:0] month,
	input  logic [cds_pkg::R400_W-1:0]  r400,
	output logic [cds_pkg::DAY_W-1:0]   len
);

	logic leap;
	logic month_ok;

	// leap: divisible by 4, and not a century unless divisible by 400
	assign leap = (r400[1:0] == 2'b00) && (r400 != cds_pkg::CENT_1) &&
		(r400 != cds_pkg::CENT_2) && (r400 != cds_pkg::CENT_3);

	assign month_ok = (month >= cds_pkg::MONTH_JAN) && (month <= cds_pkg::MONTH_DEC);

	// table lookup with february fixup
	always_comb begin
		if (!month_ok) begin
			len = '0;
		end else if (month == cds_pkg::MONTH_FEB && leap) begin
			len = cds_pkg::FEB_LEAP_LEN;
		end else begin
			len = cds_pkg::BASE_LEN[month - cds_pkg::MONTH_JAN];
		end
	end

endmodule

### hdl/calendar_date_shift_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_shift_unit: Gregorian date plus signed day offset
// Steps: the year is reduced modulo 400 by repeated subtraction of 400, the start
// date is checked, the walk crosses one month boundary at a time, and the result
// is then loaded into the output register; a bad start date skips the walk.
// Throughput: one word at a time; the month walk over the shared adder sets it.
// Reset clears the sequencer and the result valid; the payload is not reset.
// ----------------------------------------------------------------------------
module calendar_date_shift_unit (
	input  logic          clk,
	input  logic          arst_n,
	cds_in_if.sink        din,
	cds_out_if.source     dout
);

	localparam int ACC_W  = cds_pkg::ACC_W;
	localparam int YR_W   = cds_pkg::YEAR_RUN_W;
	localparam int R_W    = cds_pkg::R400_W;

	cds_pkg::state_t state_q;

	logic signed [YR_W-1:0]              year_q;
	logic [cds_pkg::MONTH_W-1:0]         month_q;
	logic [cds_pkg::DAY_W-1:0]           day_q;
	logic signed [cds_pkg::OFFSET_W-1:0] offset_q;
	logic signed [ACC_W-1:0]             acc_q;
	logic [R_W-1:0]                      r400_q;
	cds_pkg::status_t                    status_q;

	logic                                out_valid_q;
	logic [cds_pkg::YEAR_W-1:0]          out_year_q;
	logic [cds_pkg::MONTH_W-1:0]         out_month_q;
	logic [cds_pkg::DAY_W-1:0]           out_day_q;
	cds_pkg::status_t                    out_status_q;

	logic signed [ACC_W-1:0]             op_a;
	logic signed [ACC_W-1:0]             op_b;
	logic signed [ACC_W-1:0]             sum;
	logic                                walk_back;
	logic [cds_pkg::MONTH_W-1:0]         prev_month;
	logic [cds_pkg::MONTH_W-1:0]         len_month;
	logic [cds_pkg::DAY_W-1:0]           len;
	logic                                year_in_range;
	logic                                date_ok;
	logic                                in_fire;
	logic                                out_free;

	assign in_fire  = din.valid && din.ready;
	assign out_free = !out_valid_q || dout.ready;
	assign din.ready = (state_q == cds_pkg::ST_IDLE);

	// day count still at or below zero: step back a month
	assign walk_back  = (acc_q <= 0);
	assign prev_month = (month_q == cds_pkg::MONTH_JAN) ? cds_pkg::MONTH_DEC
		: month_q - cds_pkg::MONTH_W'(1);
	assign len_month  = (state_q == cds_pkg::ST_WALK && walk_back) ? prev_month : month_q;

	cds_month_len u_month_len (
		.month (len_month),
		.r400  (r400_q),
		.len   (len)
	);

	// shared adder operand select
	always_comb begin
		op_a = acc_q;
		op_b = -ACC_W'($signed({1'b0, cds_pkg::CYCLE_400}));
		unique case (state_q)
			cds_pkg::ST_MOD: begin
				op_a = acc_q;
				op_b = -ACC_W'($signed({1'b0, cds_pkg::CYCLE_400}));
			end
			cds_pkg::ST_CHECK: begin
				op_a = ACC_W'($signed({1'b0, day_q}));
				op_b = ACC_W'(offset_q);
			end
			cds_pkg::ST_WALK: begin
				op_a = acc_q;
				op_b = walk_back ? ACC_W'($signed({1'b0, len}))
					: -ACC_W'($signed({1'b0, len}));
			end
			cds_pkg::ST_IDLE, cds_pkg::ST_DONE: begin
				op_a = acc_q;
				op_b = '0;
			end
			default: begin
				op_a = acc_q;
				op_b = '0;
			end
		endcase
	end

	assign sum = op_a + op_b;

	assign year_in_range = (year_q >= $signed(YR_W'(cds_pkg::YEAR_MIN))) &&
		(year_q <= $signed(YR_W'(cds_pkg::YEAR_MAX)));
	assign date_ok = year_in_range && (day_q != '0) && (day_q <= len);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cds_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				cds_pkg::ST_IDLE: begin
					if (in_fire) state_q <= cds_pkg::ST_MOD;
				end
				cds_pkg::ST_MOD: begin
					if (sum < 0) state_q <= cds_pkg::ST_CHECK;
				end
				cds_pkg::ST_CHECK: begin
					state_q <= date_ok ? cds_pkg::ST_WALK : cds_pkg::ST_DONE;
				end
				cds_pkg::ST_WALK: begin
					if (!walk_back && sum <= 0) state_q <= cds_pkg::ST_DONE;
				end
				cds_pkg::ST_DONE: begin
					if (out_free) state_q <= cds_pkg::ST_IDLE;
				end
				default: state_q <= cds_pkg::ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cds_pkg::ST_IDLE: begin
				if (in_fire) begin
					year_q   <= YR_W'($signed({1'b0, din.in_year}));
					month_q  <= din.in_month;
					day_q    <= din.in_day;
					offset_q <= din.day_offset;
					acc_q    <= ACC_W'($signed({1'b0, din.in_year}));
				end
			end
			// repeated subtraction of 400 leaves the year residue
			cds_pkg::ST_MOD: begin
				if (sum < 0) begin
					r400_q <= acc_q[R_W-1:0];
				end else begin
					acc_q <= sum;
				end
			end
			cds_pkg::ST_CHECK: begin
				acc_q <= sum;
				status_q <= date_ok ? cds_pkg::STAT_OK : cds_pkg::STAT_BAD_DATE;
			end
			// one month boundary per cycle
			cds_pkg::ST_WALK: begin
				if (walk_back) begin
					acc_q   <= sum;
					month_q <= prev_month;
					if (month_q == cds_pkg::MONTH_JAN) begin
						year_q <= year_q - YR_W'(1);
						r400_q <= (r400_q == '0) ? cds_pkg::R400_LAST : r400_q - R_W'(1);
					end
				end else if (sum > 0) begin
					acc_q <= sum;
					if (month_q == cds_pkg::MONTH_DEC) begin
						month_q <= cds_pkg::MONTH_JAN;
						year_q  <= year_q + YR_W'(1);
						r400_q  <= (r400_q == cds_pkg::R400_LAST) ? '0 : r400_q + R_W'(1);
					end else begin
						month_q <= month_q + cds_pkg::MONTH_W'(1);
					end
				end else begin
					status_q <= year_in_range ? cds_pkg::STAT_OK : cds_pkg::STAT_OUT_RANGE;
				end
			end
			cds_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cds_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cds_pkg::ST_DONE && out_free) begin
			out_status_q <= status_q;
			if (status_q == cds_pkg::STAT_OK) begin
				out_year_q  <= year_q[cds_pkg::YEAR_W-1:0];
				out_month_q <= month_q;
				out_day_q   <= acc_q[cds_pkg::DAY_W-1:0];
			end else begin
				out_year_q  <= '0;
				out_month_q <= '0;
				out_day_q   <= '0;
			end
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.out_year  = out_year_q;
	assign dout.out_month = out_month_q;
	assign dout.out_day   = out_day_q;
	assign dout.status    = out_status_q;

	// checks
	a_walk_month: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cds_pkg::ST_WALK |->
			month_q >= cds_pkg::MONTH_JAN && month_q <= cds_pkg::MONTH_DEC)
		else $error("month left 1..12 during walk");

	a_walk_r400: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cds_pkg::ST_WALK |-> r400_q <= cds_pkg::R400_LAST)
		else $error("year residue out of range");

	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == cds_pkg::STAT_OK |->
			out_month_q >= cds_pkg::MONTH_JAN && out_month_q <= cds_pkg::MONTH_DEC &&
			out_day_q != '0 && out_year_q != '0)
		else $error("ok result with malformed date");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != cds_pkg::STAT_OK |->
			out_year_q == '0 && out_month_q == '0 && out_day_q == '0)
		else $error("error result carries a date");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == cds_pkg::ST_MOD)
		else $error("accepted word did not start reduction");

endmodule
